/* src/gls_pkg.sv */
// ----------------------------------------------------------------------------
// gls_pkg: shared types and constants of the grid line-of-sight block
// Map size, payload structures, command codes and small address helpers.
// ----------------------------------------------------------------------------
package gls_pkg;

  // Map geometry. Every tile address and bound below follows from these two.
  localparam int MAP_WIDTH  = 64;
  localparam int MAP_HEIGHT = 64;

  localparam int TILE_DEPTH  = MAP_WIDTH * MAP_HEIGHT;
  localparam int TILE_ADDR_W = $clog2(TILE_DEPTH);

  // Field widths fixed by the item format.
  localparam int COORD_W = 6;
  localparam int TILE_W  = 4;
  localparam int MASK_W  = 1 << TILE_W;

  typedef logic [COORD_W-1:0]     coord_t;
  typedef logic [TILE_W-1:0]      tile_t;
  typedef logic [MASK_W-1:0]      mask_t;
  typedef logic [TILE_ADDR_W-1:0] tile_addr_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } command_t;

  typedef struct packed {
    command_t command;
    coord_t   from_x;
    coord_t   from_y;
    coord_t   to_x;
    coord_t   to_y;
    tile_t    tile_value;
  } gls_item_t;

  typedef struct packed {
    logic visible;
  } gls_result_t;

  // True when the cell lies inside the map.
  function automatic logic cell_in_map(coord_t x, coord_t y);
    return (32'(x) < 32'(MAP_WIDTH)) && (32'(y) < 32'(MAP_HEIGHT));
  endfunction

  // Row-major tile address; only meaningful for cells inside the map.
  function automatic tile_addr_t cell_addr(coord_t x, coord_t y);
    return TILE_ADDR_W'(32'(y) * 32'(MAP_WIDTH) + 32'(x));
  endfunction

endpackage

/* src/gls_item_if.sv */
// ----------------------------------------------------------------------------
// gls_item_if / gls_result_if: valid-ready channels of the block
// A beat moves when valid and ready are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface gls_item_if;
  import gls_pkg::*;

  logic      valid;
  logic      ready;
  gls_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface gls_result_if;
  import gls_pkg::*;

  logic        valid;
  logic        ready;
  gls_result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* src/grid_line_of_sight.sv */
// ----------------------------------------------------------------------------
// grid_line_of_sight: tile map with a line-of-sight query engine
// Stores 4-bit tile types and answers whether a sampled line is unobstructed.
// ----------------------------------------------------------------------------
// Usage
//   items (sink) carries one beat per command. A write beat stores tile_value
//   at (from_x, from_y) and produces no result. A query beat walks the cells
//   strictly between (from_x, from_y) and (to_x, to_y) and produces one
//   result beat on results with visible set when every one of those cells
//   holds a tile type whose bit is set in the open-tile mask.
//   cfg_we / cfg_wdata write the open-tile mask; write it only while idle.
// Walk
//   A query steps along the major axis, the larger of |to_x - from_x| and
//   |to_y - from_y|, with one tile-RAM read per step through a single read
//   port and one shared add-and-compare unit producing the minor coordinate.
//   The block takes no new item while a query is in progress.
// Reset and stalls
//   Reset clears the sequencer, the result valid flag and the mask; the tile
//   RAM is not cleared. If results stalls, a finished query waits for the
//   output register to free up before the block accepts the next item.
// ----------------------------------------------------------------------------
module grid_line_of_sight (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  gls_item_if.sink            items,
  gls_result_if.source        results
);
  import gls_pkg::*;

  // Sequencer states: wait for an item, walk the line, hand off the answer.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  // Open-tile mask register.
  mask_t open_tile_mask;

  // Walk context, loaded when a query is accepted.
  logic   vert;       // major axis is y
  logic   maj_neg;    // major axis steps downward
  logic   min_neg;    // minor axis steps downward
  coord_t maj_len;    // |major delta|
  coord_t min_d;      // |minor delta|
  coord_t maj_c;      // current major coordinate
  coord_t min_c;      // current minor coordinate
  coord_t acc;        // remainder of k*min_d / maj_len
  coord_t step_k;     // steps taken so far

  // Read tracking and the running verdict.
  logic rd_pending;
  logic rd_oom;
  logic blocked;

  // Output register.
  logic res_valid;
  logic res_visible;

  // Tile RAM signals.
  logic       ram_we;
  tile_addr_t ram_waddr;
  logic       ram_re;
  tile_addr_t ram_raddr;
  tile_t      ram_rdata;

  // Query setup arithmetic on the incoming beat.
  logic [COORD_W:0] dx, dy;
  coord_t           adx, ady;
  logic             q_vert;

  // Step arithmetic: the shared add-and-compare unit.
  logic [COORD_W:0] acc_sum;
  logic             carry_minor;
  coord_t           acc_n, maj_n, min_n, step_n;
  coord_t           cell_x, cell_y;
  logic             more_steps;
  logic             closed;

  logic accept, accept_query, load_result;

  assign items.ready  = (state == ST_IDLE);
  assign accept       = items.valid && items.ready;
  assign accept_query = accept && (items.payload.command == CMD_QUERY);

  // Writes go straight into the tile RAM; cells outside the map are dropped.
  assign ram_we    = accept && (items.payload.command == CMD_WRITE) &&
                     cell_in_map(items.payload.from_x, items.payload.from_y);
  assign ram_waddr = cell_addr(items.payload.from_x, items.payload.from_y);

  always_comb begin
    dx     = {1'b0, items.payload.to_x} - {1'b0, items.payload.from_x};
    dy     = {1'b0, items.payload.to_y} - {1'b0, items.payload.from_y};
    adx    = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
    ady    = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
    // A tie between the axes walks horizontally.
    q_vert = (ady > adx);
  end

  // One step: advance the major axis by one and the minor axis when the
  // accumulated minor distance reaches the major length. Because min_d never
  // exceeds maj_len, a single subtraction keeps the remainder in range, which
  // reproduces the truncating division of the offset exactly.
  always_comb begin
    acc_sum     = {1'b0, acc} + {1'b0, min_d};
    carry_minor = (acc_sum >= {1'b0, maj_len});
    acc_n       = carry_minor ? COORD_W'(acc_sum - {1'b0, maj_len}) : acc;
    if (!carry_minor) begin
      acc_n = COORD_W'(acc_sum);
    end
    maj_n       = maj_neg ? maj_c - 1'b1 : maj_c + 1'b1;
    min_n       = carry_minor ? (min_neg ? min_c - 1'b1 : min_c + 1'b1) : min_c;
    step_n      = step_k + 1'b1;
    more_steps  = (step_n < maj_len);
    cell_x      = vert ? min_n : maj_n;
    cell_y      = vert ? maj_n : min_n;
  end

  assign ram_re    = (state == ST_WALK) && more_steps && cell_in_map(cell_x, cell_y);
  assign ram_raddr = cell_addr(cell_x, cell_y);

  // The read issued in the previous cycle is judged now.
  assign closed = rd_pending && (rd_oom || !open_tile_mask[ram_rdata]);

  assign load_result = (state == ST_DONE) && (!res_valid || results.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept_query) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!more_steps) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_result) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      open_tile_mask <= '0;
      rd_pending     <= 1'b0;
      blocked        <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        open_tile_mask <= cfg_wdata;
      end

      rd_pending <= (state == ST_WALK) && more_steps;

      if (accept_query) begin
        blocked <= 1'b0;
      end else if (closed) begin
        blocked <= 1'b1;
      end

      if (load_result) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Walk datapath registers.
  always_ff @(posedge clk) begin
    if (accept_query) begin
      vert    <= q_vert;
      maj_len <= q_vert ? ady : adx;
      min_d   <= q_vert ? adx : ady;
      maj_neg <= q_vert ? dy[COORD_W] : dx[COORD_W];
      min_neg <= q_vert ? dx[COORD_W] : dy[COORD_W];
      maj_c   <= q_vert ? items.payload.from_y : items.payload.from_x;
      min_c   <= q_vert ? items.payload.from_x : items.payload.from_y;
      acc     <= '0;
      step_k  <= '0;
    end else if (state == ST_WALK) begin
      maj_c  <= maj_n;
      min_c  <= min_n;
      acc    <= acc_n;
      step_k <= step_n;
    end
    rd_oom <= !cell_in_map(cell_x, cell_y);
    if (load_result) begin
      res_visible <= !blocked;
    end
  end

  assign results.valid           = res_valid;
  assign results.payload.visible = res_visible;

  gls_ram #(
    .WIDTH (TILE_W),
    .DEPTH (TILE_DEPTH)
  ) u_tile_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (items.payload.tile_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

/* src/gls_ram.sv */
// ----------------------------------------------------------------------------
// gls_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gls_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the grid line-of-sight block
// Writes tiles and line-of-sight queries through the item channel. A local
// copy of the tile map and the open-tile mask predicts every visible bit, and
// each result beat is compared against that prediction in order.
// ----------------------------------------------------------------------------
module testbench;
  import gls_pkg::*;

  // Quiet cycles waited after every query is answered, so that the block
  // is sure to have nothing left in flight.
  localparam int SETTLE_CYCLES = 70;
  localparam int RANDOM_PHASE_ITEMS = 24;
  localparam int RANDOM_PHASES = 5;

  // One outstanding query together with the answer it must produce.
  typedef struct {
    gls_item_t query;
    logic      visible;
  } sight_check_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  gls_item_if   item_ch ();
  gls_result_if result_ch ();

  grid_line_of_sight u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .items     (item_ch),
    .results   (result_ch)
  );

  // Map and mask as the block sees them at the moment each beat is accepted.
  tile_t tile_model [TILE_DEPTH];
  mask_t mask_model;

  // Which cells the stimulus has already scheduled a write for. Queries are
  // only ever generated over cells that are set here, because reading a tile
  // that was never written is outside what the block promises.
  bit planned_written [TILE_DEPTH];

  gls_item_t    pending_items [$];
  sight_check_t sight_expected [$];

  int items_queued;
  int items_accepted;
  int send_gap;
  int stall_left;
  bit sender_idling;
  bit sink_idling;

  int fail_count;
  int write_beats;
  int query_beats;
  int visible_beats;
  int mask_writes;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Line walk. The walk steps along the major axis (ties go horizontal); the
  // minor coordinate is start + offset * minor_delta / major_delta, truncated
  // toward zero, which is exactly what SystemVerilog int division does.
  // --------------------------------------------------------------------------
  function automatic int walk_length(gls_item_t it);
    int adx;
    int ady;
    adx = int'(it.to_x) - int'(it.from_x);
    ady = int'(it.to_y) - int'(it.from_y);
    if (adx < 0) adx = -adx;
    if (ady < 0) ady = -ady;
    return (ady > adx) ? ady : adx;
  endfunction

  // Cell at step k of the walk; k = 0 is the start, k = walk_length the end.
  // Never called for equal endpoints, where there is no major axis.
  function automatic void walk_cell(gls_item_t it, int k, output int x, output int y);
    int fx;
    int fy;
    int dx;
    int dy;
    int off;
    fx = int'(it.from_x);
    fy = int'(it.from_y);
    dx = int'(it.to_x) - fx;
    dy = int'(it.to_y) - fy;
    if ((dy < 0 ? -dy : dy) > (dx < 0 ? -dx : dx)) begin
      off = (dy < 0) ? -k : k;
      x = (off * dx) / dy + fx;
      y = fy + off;
    end else begin
      off = (dx < 0) ? -k : k;
      x = fx + off;
      y = (off * dy) / dx + fy;
    end
  endfunction

  // Expected visible bit: every cell strictly between the endpoints must hold
  // a tile type whose mask bit is set. Cells off the map count as closed.
  function automatic logic sight_predict(gls_item_t it);
    int n;
    int x;
    int y;
    n = walk_length(it);
    for (int k = 1; k < n; k++) begin
      walk_cell(it, k, x, y);
      if (x < 0 || y < 0 || x >= MAP_WIDTH || y >= MAP_HEIGHT) return 1'b0;
      if (!mask_model[tile_model[cell_addr(coord_t'(x), coord_t'(y))]]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders. They only append to the pending list; the driver below
  // moves the beats onto the channel.
  // --------------------------------------------------------------------------

  // Random tile type, drawn from the open types of the current mask when asked and any are open.
  function automatic tile_t pick_tile(bit want_open);
    tile_t t;
    t = tile_t'($urandom_range(0, 15));
    if (want_open && mask_model != '0) begin
      while (!mask_model[t]) t = tile_t'($urandom_range(0, 15));
    end
    return t;
  endfunction

  function automatic void queue_write(coord_t x, coord_t y, tile_t tile);
    gls_item_t it;
    it.command    = CMD_WRITE;
    it.from_x     = x;
    it.from_y     = y;
    // The end coordinates mean nothing to a write, so they carry noise.
    it.to_x       = coord_t'($urandom_range(0, 63));
    it.to_y       = coord_t'($urandom_range(0, 63));
    it.tile_value = tile;
    pending_items.push_back(it);
    planned_written[cell_addr(x, y)] = 1'b1;
    items_queued++;
  endfunction

  // A query is preceded by writes to any cell of its line that has not been
  // written yet, mostly with open tile types so that long lines can see.
  function automatic void queue_query(coord_t fx, coord_t fy, coord_t tx, coord_t ty);
    gls_item_t it;
    int n;
    int x;
    int y;
    it.command    = CMD_QUERY;
    it.from_x     = fx;
    it.from_y     = fy;
    it.to_x       = tx;
    it.to_y       = ty;
    it.tile_value = tile_t'($urandom_range(0, 15));
    n = walk_length(it);
    if (n > 0) begin
      for (int k = 0; k <= n; k++) begin
        walk_cell(it, k, x, y);
        if (!planned_written[cell_addr(coord_t'(x), coord_t'(y))])
          queue_write(coord_t'(x), coord_t'(y), pick_tile($urandom_range(0, 9) != 0));
      end
    end
    pending_items.push_back(it);
    items_queued++;
  endfunction

  // A coordinate within eight cells of c, kept on the map.
  function automatic coord_t near_coord(coord_t c);
    int v;
    v = int'(c) + int'($urandom_range(0, 16)) - 8;
    if (v < 0) v = 0;
    if (v > 63) v = 63;
    return coord_t'(v);
  endfunction

  // Mostly short queries with random walls dropped in between, a share of
  // longer lines and now and then equal endpoints. Starts stay in the 16 by 16
  // corner of the map, so the lines keep crossing cells that are already set.
  function automatic void random_phase(int count);
    coord_t fx;
    coord_t fy;
    int     shape;
    for (int i = 0; i < count; i++) begin
      fx = coord_t'($urandom_range(0, 15));
      fy = coord_t'($urandom_range(0, 15));
      if ($urandom_range(0, 9) < 4) begin
        queue_write(fx, fy, pick_tile($urandom_range(0, 1)));
      end else begin
        shape = $urandom_range(0, 19);
        if (shape == 0)
          queue_query(fx, fy, fx, fy);
        else if (shape < 14)
          queue_query(fx, fy, near_coord(fx), near_coord(fy));
        else
          queue_query(fx, fy, coord_t'($urandom_range(0, 15)),
                      coord_t'($urandom_range(0, 15)));
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Phase control
  // --------------------------------------------------------------------------

  // Holds until every queued beat has been taken and every query answered,
  // then lets the block run dry before anything is reconfigured.
  task automatic wait_idle();
    do @(posedge clk);
    while (items_accepted != items_queued || sight_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The mask is written through cfg_we; only called while the block is idle.
  task automatic set_mask(mask_t value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    mask_model = value;
    mask_writes++;
  endtask

  // --------------------------------------------------------------------------
  // Item driver. A beat stays on the channel until it is taken; after a beat
  // the sender may go quiet for a random burst.
  // Acceptance is also where the local map is updated and queries predicted,
  // so every prediction sees exactly the writes that went before it.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        items_accepted++;
        if (item_ch.payload.command == CMD_WRITE) begin
          if (cell_in_map(item_ch.payload.from_x, item_ch.payload.from_y))
            tile_model[cell_addr(item_ch.payload.from_x, item_ch.payload.from_y)] =
              item_ch.payload.tile_value;
          write_beats++;
        end else begin
          sight_expected.push_back('{item_ch.payload, sight_predict(item_ch.payload)});
          query_beats++;
        end
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          item_ch.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          item_ch.payload <= pending_items.pop_front();
          item_ch.valid   <= 1'b1;
          if (sender_idling && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 9);
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor. Each result beat is matched against the oldest query still
  // waiting. Ready drops in random bursts to stall the block's output
  // register at every point of its work.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    sight_check_t chk;
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (sight_expected.size() == 0) begin
          fail_count++;
          $display("%0t: result beat visible=%0b arrived with no query outstanding",
                   $time, result_ch.payload.visible);
        end else begin
          chk = sight_expected.pop_front();
          if (result_ch.payload.visible !== chk.visible) begin
            fail_count++;
            $display("%0t: query (%0d,%0d)->(%0d,%0d) visible expected %0b, actual %0b",
                     $time, chk.query.from_x, chk.query.from_y, chk.query.to_x,
                     chk.query.to_y, chk.visible, result_ch.payload.visible);
          end else if (chk.visible) begin
            visible_beats++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else if (sink_idling && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    mask_t phase_mask;

    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    item_ch.valid     = 1'b0;
    item_ch.payload   = '0;
    result_ch.ready   = 1'b0;
    mask_model        = '0;
    sender_idling     = 1'b1;
    sink_idling       = 1'b1;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // With the mask still at its reset value nothing is open: a line with one
    // cell in between is blocked, while equal endpoints are always visible.
    @(negedge clk);
    queue_query(6'd2, 6'd1, 6'd2, 6'd3);
    queue_query(6'd9, 6'd9, 6'd9, 6'd9);
    wait_idle();

    // Directed lines under a mask that opens tile types 0 to 7.
    set_mask(16'h00FF);
    @(negedge clk);
    queue_write(6'd0, 6'd0, 4'h0);
    queue_write(6'd63, 6'd63, 4'hF);
    queue_write(6'd63, 6'd0, 4'h8);
    queue_write(6'd0, 6'd63, 4'h7);
    // Neighbors have no cell in between, so even closed endpoints are seen.
    queue_query(6'd0, 6'd0, 6'd1, 6'd1);
    // Full-length rows and columns in both directions.
    queue_query(6'd0, 6'd10, 6'd63, 6'd10);
    queue_query(6'd63, 6'd10, 6'd0, 6'd10);
    queue_query(6'd20, 6'd0, 6'd20, 6'd63);
    queue_query(6'd20, 6'd63, 6'd20, 6'd0);
    // Exact diagonals, where the tie between the axes walks horizontally; the
    // corners at x = 63 hold closed types, but endpoints are never looked at.
    queue_query(6'd0, 6'd0, 6'd63, 6'd63);
    queue_query(6'd63, 6'd0, 6'd0, 6'd63);
    queue_query(6'd63, 6'd63, 6'd0, 6'd0);
    // Steep and shallow lines, most with negative deltas, where truncation toward
    // zero of the minor coordinate matters.
    queue_query(6'd3, 6'd2, 6'd5, 6'd20);
    queue_query(6'd30, 6'd40, 6'd12, 6'd33);
    queue_query(6'd10, 6'd10, 6'd0, 6'd13);
    queue_query(6'd12, 6'd50, 6'd15, 6'd44);
    // A closed tile dropped onto the row now blocks it from both ends.
    queue_write(6'd30, 6'd10, 4'hC);
    queue_query(6'd0, 6'd10, 6'd63, 6'd10);
    queue_query(6'd63, 6'd10, 6'd0, 6'd10);
    // Equal endpoints on a cell that was never written: no tile is read.
    queue_query(6'd40, 6'd21, 6'd40, 6'd21);
    wait_idle();

    // Random phases under both extreme masks, a mask with only type 0 open and
    // random masks. Idling varies per phase, and the last phase runs flat out.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      unique case (p)
        0: phase_mask = 16'h0000;
        1: phase_mask = 16'hFFFF;
        3: phase_mask = 16'h0001;
        default: phase_mask = mask_t'($urandom_range(0, 16'hFFFF));
      endcase
      sender_idling = (p != 2) && (p != RANDOM_PHASES - 1);
      sink_idling   = (p != 1) && (p != RANDOM_PHASES - 1);
      set_mask(phase_mask);
      @(negedge clk);
      random_phase(RANDOM_PHASE_ITEMS);
      wait_idle();
    end

    $display("Run covered %0d tile writes and %0d line-of-sight queries (%0d visible)",
             write_beats, query_beats, visible_beats);
    $display("under %0d open-tile mask settings, including all-closed and all-open.",
             mask_writes);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // A correct run needs well under a tenth of this; reaching it means the
  // block stopped taking items or stopped answering queries.
  initial begin : watchdog
    #10_000_000;
    $display("%0t: timeout with %0d queries unanswered", $time, sight_expected.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
